// ----- hdl/hc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hc_pkg;

   localparam int unsigned MODULUS    = 26;
   localparam logic [6:0]  LETTER_A   = 7'd97;
   localparam logic [4:0]  PAD_LETTER = 5'd23;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_KEY_R0C0     = 3'd0,
      CSR_KEY_R0C1     = 3'd1,
      CSR_KEY_R1C0     = 3'd2,
      CSR_KEY_R1C1     = 3'd3,
      CSR_DECRYPT_MODE = 3'd4
   } csr_index_type;

   // Key registers as the back end sees them.
   typedef struct packed {
      logic [4:0] k00;
      logic [4:0] k01;
      logic [4:0] k10;
      logic [4:0] k11;
      logic       decrypt;
   } key_type;

   // One letter pair waiting for the matrix product.
   typedef struct packed {
      logic [4:0] v0;
      logic [4:0] v1;
   } pair_type;

   // Remainder modulo 26 of a value below 1664, by six compare-subtract steps.
   function automatic logic [4:0] mod26(input logic [10:0] x);
      logic [10:0] r;
      r = x;
      for (int i = 5; i >= 0; i--) begin
         if (r >= 11'(MODULUS << i)) begin
            r = r - 11'(MODULUS << i);
         end
      end
      return r[4:0];
   endfunction

   // Additive inverse modulo 26 of a value below 1664.
   function automatic logic [4:0] neg_mod26(input logic [10:0] x);
      logic [4:0] r;
      r = mod26(x);
      return (r == 5'd0) ? 5'd0 : 5'(MODULUS) - r;
   endfunction

   // Inverse of a residue modulo 26; zero where none exists.
   function automatic logic [4:0] det_inverse(input logic [4:0] d);
      logic [4:0] r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/hc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_message;

   modport source (output valid, output in_char, output end_of_message, input ready);
   modport sink   (input valid, input in_char, input end_of_message, output ready);
endinterface

interface hc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_of_pair;
   logic       key_error;

   modport source (output valid, output out_char, output last_of_pair,
                   output key_error, input ready);
   modport sink   (input valid, input out_char, input last_of_pair,
                   input key_error, output ready);
endinterface

`default_nettype wire

// ----- hdl/hc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hc_front
   import hc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   hc_req_if.sink        req,
   output logic          push,
   output pair_type      push_pair,
   input  wire logic     queue_full
);

   logic [4:0] held_ff, held_in;
   logic       holding_ff, holding_in;
   logic [4:0] letter;
   logic       accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign letter    = mod26(11'(req.in_char) + 11'd163);

   // A pair is complete on the second letter, or on an unpaired final letter.
   assign push         = accept && (holding_ff || req.end_of_message);
   assign push_pair.v0 = holding_ff ? held_ff : letter;
   assign push_pair.v1 = holding_ff ? letter : PAD_LETTER;

   always_comb begin
      held_in    = held_ff;
      holding_in = holding_ff;
      if (accept) begin
         if (holding_ff) begin
            holding_in = 1'b0;
         end else if (!req.end_of_message) begin
            held_in    = letter;
            holding_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 5'd0;
         holding_ff <= 1'b0;
      end else begin
         held_ff    <= held_in;
         holding_ff <= holding_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/hc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hc_queue
   import hc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire pair_type push_pair,
   output logic          full,
   output logic          pop_valid,
   output pair_type      pop_pair,
   input  wire logic     pop
);

   pair_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_pair  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/hc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hc_back
   import hc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire key_type  key,
   input  wire logic     pop_valid,
   input  wire pair_type pop_pair,
   output logic          pop,
   hc_rsp_if.source      rsp
);

   // Reduced key entries.
   logic [4:0] ka, kb, kc, kd;
   logic [9:0] prod_ad, prod_bc;

   // Stage 1: determinant.
   logic       s1_valid_ff, s1_valid_in;
   pair_type   s1_pair_ff;
   logic [4:0] s1_det_ff;

   // Stage 2: active matrix.
   logic       s2_valid_ff, s2_valid_in;
   pair_type   s2_pair_ff;
   logic [4:0] s2_m00_ff, s2_m01_ff, s2_m10_ff, s2_m11_ff;
   logic       s2_err_ff;
   logic [4:0] di;
   logic       err;
   logic [4:0] m00, m01, m10, m11;

   // Stage 3: result pair, sent as two beats.
   logic       s3_valid_ff, s3_valid_in;
   logic       s3_phase_ff, s3_phase_in;
   logic [4:0] s3_r0_ff, s3_r1_ff;
   logic       s3_err_ff;
   logic [9:0] p00, p01, p10, p11;

   logic       s1_load, s2_load, s3_load, rsp_done;

   function automatic logic [4:0] reduce_key(input logic [4:0] k);
      return (k >= 5'(MODULUS)) ? k - 5'(MODULUS) : k;
   endfunction

   assign ka = reduce_key(key.k00);
   assign kb = reduce_key(key.k01);
   assign kc = reduce_key(key.k10);
   assign kd = reduce_key(key.k11);

   assign rsp_done = rsp.valid && rsp.ready && s3_phase_ff;
   assign s3_load  = s2_valid_ff && (!s3_valid_ff || rsp_done);
   assign s2_load  = s1_valid_ff && (!s2_valid_ff || s3_load);
   assign s1_load  = pop_valid && (!s1_valid_ff || s2_load);
   assign pop      = s1_load;

   assign prod_ad = ka * kd;
   assign prod_bc = kb * kc;

   assign di  = det_inverse(s1_det_ff);
   assign err = key.decrypt && (di == 5'd0);

   always_comb begin
      m00 = ka;
      m01 = kb;
      m10 = kc;
      m11 = kd;
      if (key.decrypt) begin
         m00 = mod26(11'(di) * 11'(kd));
         m11 = mod26(11'(di) * 11'(ka));
         m01 = neg_mod26(11'(di) * 11'(kb));
         m10 = neg_mod26(11'(di) * 11'(kc));
      end
   end

   assign p00 = s2_m00_ff * s2_pair_ff.v0;
   assign p01 = s2_m01_ff * s2_pair_ff.v1;
   assign p10 = s2_m10_ff * s2_pair_ff.v0;
   assign p11 = s2_m11_ff * s2_pair_ff.v1;

   always_comb begin
      s1_valid_in = s1_load || (s1_valid_ff && !s2_load);
      s2_valid_in = s2_load || (s2_valid_ff && !s3_load);
      s3_valid_in = s3_load || (s3_valid_ff && !rsp_done);
      s3_phase_in = s3_phase_ff;
      if (rsp.valid && rsp.ready) begin
         s3_phase_in = !s3_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pair_ff <= pop_pair;
         s1_det_ff  <= mod26(11'(prod_ad) + 11'd676 - 11'(prod_bc));
      end
      if (s2_load) begin
         s2_pair_ff <= s1_pair_ff;
         s2_err_ff  <= err;
         // A zero matrix drives both letters to 'a' on a key error.
         s2_m00_ff  <= err ? 5'd0 : m00;
         s2_m01_ff  <= err ? 5'd0 : m01;
         s2_m10_ff  <= err ? 5'd0 : m10;
         s2_m11_ff  <= err ? 5'd0 : m11;
      end
      if (s3_load) begin
         s3_r0_ff  <= mod26(11'(p00) + 11'(p01));
         s3_r1_ff  <= mod26(11'(p10) + 11'(p11));
         s3_err_ff <= s2_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s3_phase_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s3_phase_ff <= s3_phase_in;
      end
   end

   assign rsp.valid        = s3_valid_ff;
   assign rsp.out_char     = (s3_phase_ff ? 7'(s3_r1_ff) : 7'(s3_r0_ff)) + LETTER_A;
   assign rsp.last_of_pair = s3_phase_ff;
   assign rsp.key_error    = s3_err_ff;

endmodule

`default_nettype wire

// ----- hdl/hill_cipher_2x2_mod26.sv -----
`timescale 1ns / 1ps
`default_nettype none

// 2x2 Hill cipher over lowercase letters. Each request beat carries one byte,
// taken as (byte - 'a') mod 26. The first letter of a pair is held; the second
// letter sends the pair on, and two response beats follow with the key matrix
// times the pair vector mod 26, the second beat marked by last_of_pair. A lone
// letter flagged end_of_message is paired with 'x'. In decrypt mode the modular
// inverse of the key is used; if the key has none, key_error is set and both
// letters come out as 'a'. The block takes one request beat every cycle while
// the queue has room and sends one response beat every cycle while ready is
// high, so a pair of inputs and its pair of outputs balance. The response port
// sets the rate, sending a pair's letters as two beats; a two-entry pair queue
// between the front end and the three-stage matrix pipeline absorbs short
// response stalls; a completed pair is registered in it, then in stages 1-3.
// Key registers are meant to be written only while no pair is in flight.

module hill_cipher_2x2_mod26
   import hc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   hc_req_if.sink          req_bus,
   hc_rsp_if.source        rsp_bus,
   input  wire logic       csr_wr_en,
   input  wire logic [2:0] csr_index,
   input  wire logic [4:0] csr_wdata
);

   // Key and mode registers, reset to the default key {{9, 4}, {5, 7}}.
   key_type  key_ff, key_in;

   logic     push;
   pair_type push_pair;
   logic     queue_full;
   logic     pop_valid;
   pair_type pop_pair;
   logic     pop;

   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_R0C0:     key_in.k00     = csr_wdata;
            CSR_KEY_R0C1:     key_in.k01     = csr_wdata;
            CSR_KEY_R1C0:     key_in.k10     = csr_wdata;
            CSR_KEY_R1C1:     key_in.k11     = csr_wdata;
            CSR_DECRYPT_MODE: key_in.decrypt = csr_wdata[0];
            default:          key_in         = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.k00     <= 5'd9;
         key_ff.k01     <= 5'd4;
         key_ff.k10     <= 5'd5;
         key_ff.k11     <= 5'd7;
         key_ff.decrypt <= 1'b0;
      end else begin
         key_ff <= key_in;
      end
   end

   // The front end pairs letters; a held letter survives key writes.
   hc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push       (push),
      .push_pair  (push_pair),
      .queue_full (queue_full)
   );

   hc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pair (push_pair),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_pair  (pop_pair),
      .pop       (pop)
   );

   // The back end derives the active matrix and sends each pair as two beats.
   hc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .key       (key_ff),
      .pop_valid (pop_valid),
      .pop_pair  (pop_pair),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire
